>>> hdl/clle_pkg.sv
// Shared types and codes for the cursor linked list engine.
// Depends on nothing; used by cursor_linked_list_engine.
package clle_pkg;

   // Operation codes carried in the func field
   localparam logic [1:0] FUNC_INSERT   = 2'd0;
   localparam logic [1:0] FUNC_DELETE   = 2'd1;
   localparam logic [1:0] FUNC_TRAVERSE = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_POS = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0] func;
      logic [5:0] position;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] element;
      logic       has_element;
      logic [5:0] list_length;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_INS_POP,
      ST_INS_LINK,
      ST_INS_WALK,
      ST_INS_SPLICE,
      ST_DEL_WALK,
      ST_DEL_Q,
      ST_DEL_FREE,
      ST_DEL_HEAD,
      ST_TRV_HEAD,
      ST_TRV_EMIT
   } state_type;

endpackage

>>> hdl/cursor_linked_list_engine.sv
// Cursor linked list engine: byte list threaded through a slot pool, with a free chain.
// Depends on clle_pkg (types, operation and status codes).

// A byte list lives in a pool of ENTRIES slots: slot 0 heads the free chain,
// slot ENTRIES-1 heads the list, so up to ENTRIES-2 elements fit. Links sit
// in a single-port-write memory with a registered read, and every operation
// walks it one link per clock. After reset a set-up pass writes the free
// chain, one slot a cycle, with busy high until all slots are written. An
// item is taken when start is high and busy low. An insert holds busy while
// it pops a free slot, walks to the predecessor and splices (the pop alone
// if the pool is full); a delete while it walks, unlinks and frees the victim;
// a traverse while it emits one element per cycle. A bad position, an empty
// traverse or an unused func code is answered without raising busy. Each
// result appears on rsp_item for one cycle with rsp_strobe high; there is no
// back-pressure, so the receiver must take every result as it comes.
module cursor_linked_list_engine #(
   parameter int ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  clle_pkg::req_type req_item,
   output logic              rsp_strobe,
   output clle_pkg::rsp_type rsp_item
);

   localparam int LinkW = $clog2(ENTRIES);
   localparam int CntW  = $clog2(ENTRIES);
   localparam int CmpW  = ((CntW > 6) ? CntW : 6) + 1;
   localparam logic [LinkW-1:0] HEAD = LinkW'(ENTRIES - 1);
   localparam logic [LinkW-1:0] FREE = '0;

   // Pool memories
   logic [LinkW-1:0] link_mem [ENTRIES];
   logic [7:0]       data_mem [ENTRIES];

   // Registers
   clle_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [LinkW-1:0]    p_ff, p_in;
   logic [LinkW-1:0]    j_ff, j_in;
   logic [LinkW-1:0]    init_ff, init_in;
   logic [7:0]          val_ff, val_in;
   logic [LinkW-1:0]    rd_link_ff;
   logic [7:0]          rd_data_ff;
   logic                rsp_strobe_ff, rsp_strobe_in;
   clle_pkg::rsp_type   rsp_ff, rsp_in;

   // Memory access controls
   logic [LinkW-1:0] rd_addr;
   logic             link_we;
   logic [LinkW-1:0] link_waddr;
   logic [LinkW-1:0] link_wdata;
   logic             data_we;

   // Decode of the incoming item and of the link just read
   logic             accept;
   logic [5:0]       pos_m1;
   logic [CmpW-1:0]  pos_ext;
   logic [CmpW-1:0]  count_ext;
   logic             ins_ok;
   logic             del_ok;
   logic [LinkW-1:0] nx;
   logic             pool_full;
   logic             walk_done;
   logic             trv_fin;
   logic [LinkW-1:0] init_link;

   assign accept    = start && (state_ff == clle_pkg::ST_IDLE);
   assign pos_m1    = req_item.position - 6'd1;
   assign pos_ext   = CmpW'(req_item.position);
   assign count_ext = CmpW'(count_ff);
   assign ins_ok    = (req_item.position != 6'd0) && (pos_ext <= count_ext + CmpW'(1));
   assign del_ok    = (req_item.position != 6'd0) && (pos_ext <= count_ext);

   // A link beyond the pool ends the chain
   assign nx = ({1'b0, rd_link_ff} < (LinkW + 1)'(ENTRIES)) ? rd_link_ff : FREE;

   assign pool_full = (nx == FREE) || (nx == HEAD);
   assign walk_done = (cnt_ff == '0);
   assign trv_fin   = (nx == FREE) || (cnt_ff == '0);

   // Start-up free chain: i -> i+1, the last free slot and the head end it
   assign init_link = ({1'b0, init_ff} <= (LinkW + 1)'(ENTRIES - 3))
                      ? init_ff + LinkW'(1) : FREE;

   assign busy       = (state_ff != clle_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         clle_pkg::ST_INIT: begin
            if (init_ff == HEAD) state_in = clle_pkg::ST_IDLE;
         end
         clle_pkg::ST_IDLE: begin
            if (start) begin
               case (req_item.func)
                  clle_pkg::FUNC_INSERT: begin
                     if (ins_ok) state_in = clle_pkg::ST_INS_POP;
                  end
                  clle_pkg::FUNC_DELETE: begin
                     if (del_ok) state_in = clle_pkg::ST_DEL_WALK;
                  end
                  clle_pkg::FUNC_TRAVERSE: begin
                     if (count_ff != '0) state_in = clle_pkg::ST_TRV_HEAD;
                  end
                  default: state_in = clle_pkg::ST_IDLE;
               endcase
            end
         end
         clle_pkg::ST_INS_POP: begin
            state_in = pool_full ? clle_pkg::ST_IDLE : clle_pkg::ST_INS_LINK;
         end
         clle_pkg::ST_INS_LINK:   state_in = clle_pkg::ST_INS_WALK;
         clle_pkg::ST_INS_WALK: begin
            if (walk_done) state_in = clle_pkg::ST_INS_SPLICE;
         end
         clle_pkg::ST_INS_SPLICE: state_in = clle_pkg::ST_IDLE;
         clle_pkg::ST_DEL_WALK: begin
            if (walk_done) state_in = (nx == FREE) ? clle_pkg::ST_IDLE : clle_pkg::ST_DEL_Q;
         end
         clle_pkg::ST_DEL_Q:      state_in = clle_pkg::ST_DEL_FREE;
         clle_pkg::ST_DEL_FREE:   state_in = clle_pkg::ST_DEL_HEAD;
         clle_pkg::ST_DEL_HEAD:   state_in = clle_pkg::ST_IDLE;
         clle_pkg::ST_TRV_HEAD: begin
            state_in = (nx == FREE) ? clle_pkg::ST_IDLE : clle_pkg::ST_TRV_EMIT;
         end
         clle_pkg::ST_TRV_EMIT: begin
            if (trv_fin) state_in = clle_pkg::ST_IDLE;
         end
         default: state_in = clle_pkg::ST_IDLE;
      endcase
   end

   // Datapath, memory controls and results
   always_comb begin
      count_in      = count_ff;
      cnt_in        = cnt_ff;
      p_in          = p_ff;
      j_in          = j_ff;
      init_in       = init_ff;
      val_in        = val_ff;
      rd_addr       = HEAD;
      link_we       = 1'b0;
      link_waddr    = FREE;
      link_wdata    = FREE;
      data_we       = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      rsp_in.status = clle_pkg::STATUS_OK;
      rsp_in.last   = 1'b1;

      case (state_ff)
         clle_pkg::ST_INIT: begin
            link_we    = 1'b1;
            link_waddr = init_ff;
            link_wdata = init_link;
            init_in    = init_ff + LinkW'(1);
         end
         clle_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_item.func)
                  clle_pkg::FUNC_INSERT: begin
                     if (ins_ok) begin
                        val_in  = req_item.value;
                        cnt_in  = CntW'(pos_m1);
                        rd_addr = FREE;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = clle_pkg::STATUS_BAD_POS;
                     end
                  end
                  clle_pkg::FUNC_DELETE: begin
                     if (del_ok) begin
                        p_in    = HEAD;
                        cnt_in  = CntW'(pos_m1);
                        rd_addr = HEAD;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = clle_pkg::STATUS_BAD_POS;
                     end
                  end
                  clle_pkg::FUNC_TRAVERSE: begin
                     if (count_ff != '0) begin
                        cnt_in  = count_ff - CntW'(1);
                        rd_addr = HEAD;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  default: rsp_strobe_in = 1'b1;
               endcase
            end
         end
         // First free slot arrives; fetch its successor
         clle_pkg::ST_INS_POP: begin
            if (pool_full) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = clle_pkg::STATUS_FULL;
            end else begin
               j_in    = nx;
               rd_addr = nx;
            end
         end
         // Pop the slot off the free chain and start the walk
         clle_pkg::ST_INS_LINK: begin
            link_we    = 1'b1;
            link_waddr = FREE;
            link_wdata = nx;
            p_in       = HEAD;
            rd_addr    = HEAD;
         end
         // Walk to the predecessor; on arrival store the byte and its link
         clle_pkg::ST_INS_WALK: begin
            if (!walk_done) begin
               p_in    = nx;
               cnt_in  = cnt_ff - CntW'(1);
               rd_addr = nx;
            end else begin
               link_we    = 1'b1;
               link_waddr = j_ff;
               link_wdata = nx;
               data_we    = 1'b1;
            end
         end
         clle_pkg::ST_INS_SPLICE: begin
            link_we       = 1'b1;
            link_waddr    = p_ff;
            link_wdata    = j_ff;
            count_in      = count_ff + CntW'(1);
            rsp_strobe_in = 1'b1;
         end
         // Walk to the predecessor; j holds the victim slot afterwards
         clle_pkg::ST_DEL_WALK: begin
            if (!walk_done) begin
               p_in    = nx;
               cnt_in  = cnt_ff - CntW'(1);
               rd_addr = nx;
            end else if (nx == FREE) begin
               rsp_strobe_in = 1'b1;
            end else begin
               j_in    = nx;
               rd_addr = nx;
            end
         end
         clle_pkg::ST_DEL_Q: begin
            link_we    = 1'b1;
            link_waddr = p_ff;
            link_wdata = nx;
            rd_addr    = FREE;
         end
         clle_pkg::ST_DEL_FREE: begin
            link_we    = 1'b1;
            link_waddr = j_ff;
            link_wdata = nx;
         end
         clle_pkg::ST_DEL_HEAD: begin
            link_we       = 1'b1;
            link_waddr    = FREE;
            link_wdata    = j_ff;
            count_in      = count_ff - CntW'(1);
            rsp_strobe_in = 1'b1;
         end
         clle_pkg::ST_TRV_HEAD: begin
            if (nx == FREE) begin
               rsp_strobe_in = 1'b1;
            end else begin
               p_in    = nx;
               rd_addr = nx;
            end
         end
         // One element per cycle: data and link of p arrive together
         clle_pkg::ST_TRV_EMIT: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.element     = rd_data_ff;
            rsp_in.has_element = 1'b1;
            rsp_in.last        = trv_fin;
            if (!trv_fin) begin
               p_in    = nx;
               cnt_in  = cnt_ff - CntW'(1);
               rd_addr = nx;
            end
         end
         default: rsp_strobe_in = 1'b0;
      endcase

      rsp_in.list_length = 6'(count_in);
   end

   // Pool memories: each takes one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (data_we) data_mem[j_ff] <= val_ff;
      rd_link_ff <= link_mem[rd_addr];
      rd_data_ff <= data_mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= clle_pkg::ST_INIT;
         init_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      p_ff   <= p_in;
      j_ff   <= j_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

endmodule
